@@ rtl/gtdc_pkg.sv @@
// Shared widths, register indexes, reset values and handshake structs for the drift compensator.
`default_nettype none
package gtdc_pkg;

   localparam int AXES       = 3;
   localparam int AXIS_W     = 2;
   localparam int RATE_W     = 16;
   localparam int TEMP_W     = 16;
   localparam int DELTA_W    = 17;
   localparam int BIAS_W     = 32;
   localparam int SLOPE_W    = 24;
   localparam int RES_W      = 36;
   localparam int MUL_W      = 29;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int ACC_W      = 62;
   localparam int NUM_W      = 62;
   localparam int DEN_W      = 34;
   localparam int QUO_W      = 36;
   localparam int QSTEPS     = QUO_W;
   localparam int QCNT_W     = $clog2(QSTEPS);
   localparam int SUM_W      = 57;
   localparam int WIDE_W     = 40;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_STILL_LIMIT = 3'd0;
   localparam csr_index_type CSR_ACCEL_LOW   = 3'd1;
   localparam csr_index_type CSR_ACCEL_HIGH  = 3'd2;
   localparam csr_index_type CSR_BIAS_RATE   = 3'd3;
   localparam csr_index_type CSR_SLOPE_RATE  = 3'd4;
   localparam csr_index_type CSR_SLOPE_LIMIT = 3'd5;

   localparam logic [15:0] RST_STILL_LIMIT = 16'd41;
   localparam logic [15:0] RST_ACCEL_LOW   = 16'd1843;
   localparam logic [15:0] RST_ACCEL_HIGH  = 16'd2253;
   localparam logic [23:0] RST_BIAS_RATE   = 24'd167772;
   localparam logic [23:0] RST_SLOPE_RATE  = 24'd8389;
   localparam logic [14:0] RST_SLOPE_LIMIT = 15'd12800;

   typedef logic signed [MUL_W-1:0] mul_op_type;

   typedef struct packed {
      logic                    start;
      logic signed [NUM_W-1:0] num;
      logic [DEN_W-1:0]        den;
   } div_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [QUO_W-1:0] quo;
   } div_rsp_type;

endpackage
`default_nettype wire

@@ rtl/gtdc_if.sv @@
// Valid/ready channel interfaces for gyro samples and compensated results.
`default_nettype none
interface gtdc_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] rate_x;
   logic signed [15:0] rate_y;
   logic signed [15:0] rate_z;
   logic signed [15:0] temperature;
   logic [15:0]        accel_magnitude;

   modport source (output valid, rate_x, rate_y, rate_z, temperature, accel_magnitude,
                   input ready);
   modport sink (input valid, rate_x, rate_y, rate_z, temperature, accel_magnitude,
                 output ready);
endinterface

interface gtdc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] fixed_x;
   logic signed [15:0] fixed_y;
   logic signed [15:0] fixed_z;
   logic               was_still;

   modport source (output valid, fixed_x, fixed_y, fixed_z, was_still, input ready);
   modport sink (input valid, fixed_x, fixed_y, fixed_z, was_still, output ready);
endinterface
`default_nettype wire

@@ rtl/gtdc_mul.sv @@
// Shared signed multiplier with registered product.
`default_nettype none
module gtdc_mul (
   input  logic                                 clock,
   input  gtdc_pkg::mul_op_type                 op_a,
   input  gtdc_pkg::mul_op_type                 op_b,
   output logic signed [gtdc_pkg::PROD_W-1:0]   prod_ff
);

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

endmodule
`default_nettype wire

@@ rtl/gtdc_div.sv @@
// Restoring divider, one quotient bit per cycle, quotient truncated toward zero.
`default_nettype none
module gtdc_div (
   input  logic                  clock,
   input  logic                  reset,
   input  gtdc_pkg::div_req_type div_req,
   output gtdc_pkg::div_rsp_type div_rsp
);

   logic                                busy_ff;
   logic                                done_ff;
   logic                                neg_ff;
   logic [gtdc_pkg::QCNT_W-1:0]         count_ff;
   logic [gtdc_pkg::DEN_W:0]            rem_ff;
   logic [gtdc_pkg::DEN_W-1:0]          den_ff;
   logic [gtdc_pkg::QUO_W-1:0]          quo_ff;
   logic signed [gtdc_pkg::QUO_W-1:0]   q_ff;

   logic [gtdc_pkg::NUM_W-1:0]          mag;
   logic [gtdc_pkg::DEN_W:0]            rem_sh;
   logic                                ge;
   logic [gtdc_pkg::QUO_W-1:0]          qmag_next;

   always_comb begin
      mag       = div_req.num[gtdc_pkg::NUM_W-1] ? $unsigned(-div_req.num)
                                                 : $unsigned(div_req.num);
      rem_sh    = {rem_ff[gtdc_pkg::DEN_W-1:0], quo_ff[gtdc_pkg::QUO_W-1]};
      ge        = rem_sh >= {1'b0, den_ff};
      qmag_next = {quo_ff[gtdc_pkg::QUO_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
            neg_ff   <= div_req.num[gtdc_pkg::NUM_W-1];
            den_ff   <= div_req.den;
            rem_ff   <= (gtdc_pkg::DEN_W+1)'(mag >> gtdc_pkg::QUO_W);
            quo_ff   <= mag[gtdc_pkg::QUO_W-1:0];
         end else if (busy_ff) begin
            rem_ff   <= ge ? rem_sh - {1'b0, den_ff} : rem_sh;
            quo_ff   <= qmag_next;
            count_ff <= count_ff + 1'b1;
            if (count_ff == gtdc_pkg::QCNT_W'(gtdc_pkg::QSTEPS-1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
               q_ff    <= neg_ff ? -$signed(qmag_next) : $signed(qmag_next);
            end
         end
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = q_ff;

endmodule
`default_nettype wire

@@ rtl/gyro_temp_drift_comp.sv @@
// Top level: gyro temperature drift compensator with sequencer around a shared multiplier.
//
//  channel  | direction | beat contents
//  ---------+-----------+---------------------------------------------------------
//  req_if   | in        | rate_x, rate_y, rate_z, temperature, accel_magnitude
//  rsp_if   | out       | fixed_x, fixed_y, fixed_z, was_still
//  csr_*    | in        | csr_we, csr_index, csr_wdata (write only)
//
// How long a sample takes from acceptance to a valid result depends on whether
// adaptation runs; then the 36-step divider (once per axis) and the single
// shared multiplier set its length.
// Reset is synchronous and active high; it clears the learned state and restores
// register defaults. The block takes one sample at a time; a finished result
// waits in the output register while the next sample is accepted.
`default_nettype none
module gyro_temp_drift_comp (
   input  logic                                 clock,
   input  logic                                 reset,
   gtdc_req_if.sink                             req_if,
   gtdc_rsp_if.source                           rsp_if,
   input  logic                                 csr_we,
   input  gtdc_pkg::csr_index_type              csr_index,
   input  logic [gtdc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_LOAD_D, ST_ISS_DSQ, ST_ISS_LSQ, ST_GET_LSQ,
      ST_ISS_EST, ST_GET_EST, ST_ISS_SQ, ST_GET_SQ, ST_DECIDE,
      ST_ISS_BH, ST_ISS_BL, ST_ISS_NH, ST_ISS_NL, ST_GET_NUM,
      ST_WAIT_DIV, ST_ISS_QH, ST_ISS_QL, ST_GET_Q, ST_OUTPUT
   } state_type;

   // Configuration registers
   logic [15:0] still_limit_ff;
   logic [15:0] accel_low_ff;
   logic [15:0] accel_high_ff;
   logic [23:0] bias_rate_ff;
   logic [23:0] slope_rate_ff;
   logic [14:0] slope_limit_ff;

   // Learned state
   logic                                   primed_ff;
   logic signed [gtdc_pkg::TEMP_W-1:0]     ref_ff;
   logic signed [gtdc_pkg::BIAS_W-1:0]     bias_ff  [gtdc_pkg::AXES];
   logic signed [gtdc_pkg::SLOPE_W-1:0]    slope_ff [gtdc_pkg::AXES];

   // Per-sample working registers
   state_type                              state_ff;
   logic [gtdc_pkg::AXIS_W-1:0]            axis_ff;
   logic                                   pass_ff;
   logic signed [gtdc_pkg::RATE_W-1:0]     rate_ff  [gtdc_pkg::AXES];
   logic signed [gtdc_pkg::RES_W-1:0]      res_ff   [gtdc_pkg::AXES];
   logic signed [gtdc_pkg::TEMP_W-1:0]     temp_ff;
   logic [15:0]                            accel_ff;
   logic signed [gtdc_pkg::DELTA_W-1:0]    d_ff;
   logic [gtdc_pkg::DEN_W-1:0]             denom_ff;
   logic [31:0]                            lim2_ff;
   logic [gtdc_pkg::SUM_W-1:0]             sum_ff;
   logic signed [gtdc_pkg::ACC_W-1:0]      acc_ff;
   logic                                   still_ff;

   // Result register
   logic                                   rsp_valid_ff;
   logic signed [15:0]                     fixed_x_ff;
   logic signed [15:0]                     fixed_y_ff;
   logic signed [15:0]                     fixed_z_ff;
   logic                                   was_still_ff;

   // Shared units
   gtdc_pkg::mul_op_type                   op_a;
   gtdc_pkg::mul_op_type                   op_b;
   logic signed [gtdc_pkg::PROD_W-1:0]     prod;
   gtdc_pkg::div_req_type                  div_req;
   gtdc_pkg::div_rsp_type                  div_rsp;

   // Datapath around the sequencer
   logic                                   req_take;
   logic                                   rsp_free;
   logic                                   axis_last;
   logic signed [gtdc_pkg::RATE_W-1:0]     cur_rate;
   logic signed [gtdc_pkg::BIAS_W-1:0]     cur_bias;
   logic signed [gtdc_pkg::SLOPE_W-1:0]    cur_slope;
   logic signed [gtdc_pkg::RES_W-1:0]      cur_res;
   logic signed [gtdc_pkg::RES_W-1:0]      res_new;
   logic signed [gtdc_pkg::ACC_W-1:0]      prod_hi;
   logic signed [gtdc_pkg::ACC_W-1:0]      acc_sum;
   logic signed [gtdc_pkg::WIDE_W-1:0]     step;
   logic signed [gtdc_pkg::WIDE_W-1:0]     bias_wide;
   logic signed [gtdc_pkg::WIDE_W-1:0]     slope_wide;
   logic signed [gtdc_pkg::WIDE_W-1:0]     slim;
   logic signed [gtdc_pkg::BIAS_W-1:0]     bias_new;
   logic signed [gtdc_pkg::SLOPE_W-1:0]    slope_new;
   logic                                   still_now;

   localparam logic signed [gtdc_pkg::WIDE_W-1:0] I32_MAX = 40'sh00_7FFF_FFFF;
   localparam logic signed [gtdc_pkg::WIDE_W-1:0] I32_MIN = 40'shFF_8000_0000;

   // Round to whole LSB and saturate to int16.
   function automatic logic signed [15:0] sat16(input logic signed [gtdc_pkg::RES_W-1:0] r);
      logic signed [gtdc_pkg::RES_W:0] rnd;
      logic signed [gtdc_pkg::RES_W:0] sh;
      rnd = (gtdc_pkg::RES_W+1)'(r) + 37'sd32768;
      sh  = rnd >>> 16;
      if (sh > 37'sd32767) begin
         return 16'sh7FFF;
      end else if (sh < -37'sd32768) begin
         return 16'sh8000;
      end else begin
         return sh[15:0];
      end
   endfunction

   gtdc_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod_ff (prod)
   );

   gtdc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_if.ready     = (state_ff == ST_IDLE);
   assign req_take         = req_if.valid && (state_ff == ST_IDLE);
   assign rsp_free         = !rsp_valid_ff || rsp_if.ready;
   assign axis_last        = (axis_ff == gtdc_pkg::AXIS_W'(gtdc_pkg::AXES-1));

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.fixed_x   = fixed_x_ff;
   assign rsp_if.fixed_y   = fixed_y_ff;
   assign rsp_if.fixed_z   = fixed_z_ff;
   assign rsp_if.was_still = was_still_ff;

   always_comb begin
      cur_rate  = rate_ff[axis_ff];
      cur_bias  = bias_ff[axis_ff];
      cur_slope = slope_ff[axis_ff];
      cur_res   = res_ff[axis_ff];

      // Residual in Q.16: rate*65536 - (bias + floor(slope*d/256)).
      res_new = $signed({{4{cur_rate[15]}}, cur_rate, 16'h0000})
                - gtdc_pkg::RES_W'(cur_bias)
                - $signed(prod[43:8]);

      // High partial product lands 18 bits up; add the low one to finish.
      prod_hi = gtdc_pkg::ACC_W'(prod) <<< 18;
      acc_sum = acc_ff + gtdc_pkg::ACC_W'(prod);
      step    = gtdc_pkg::WIDE_W'(acc_sum >>> 24);

      bias_wide = gtdc_pkg::WIDE_W'(cur_bias) + step;
      if (bias_wide > I32_MAX) begin
         bias_new = I32_MAX[31:0];
      end else if (bias_wide < I32_MIN) begin
         bias_new = I32_MIN[31:0];
      end else begin
         bias_new = bias_wide[31:0];
      end

      slim       = $signed({17'b0, slope_limit_ff, 8'b0});
      slope_wide = gtdc_pkg::WIDE_W'(cur_slope) + step;
      if (slope_wide > slim) begin
         slope_new = slim[gtdc_pkg::SLOPE_W-1:0];
      end else if (slope_wide < -slim) begin
         slope_new = 24'(-slim);
      end else begin
         slope_new = slope_wide[gtdc_pkg::SLOPE_W-1:0];
      end

      // Squared norms compared directly; limits crossed means never still.
      still_now = (sum_ff < {9'b0, lim2_ff, 16'h0000})
                  && (accel_ff > accel_low_ff) && (accel_ff < accel_high_ff);

      div_req.start = (state_ff == ST_GET_NUM);
      div_req.num   = acc_sum <<< 8;
      div_req.den   = denom_ff;
   end

   // Operand select for the shared multiplier; the product is registered and appears in the cycle after.
   always_comb begin
      case (state_ff)
         ST_ISS_DSQ: begin
            op_a = gtdc_pkg::MUL_W'(d_ff);
            op_b = gtdc_pkg::MUL_W'(d_ff);
         end
         ST_ISS_LSQ: begin
            op_a = $signed(gtdc_pkg::MUL_W'(still_limit_ff));
            op_b = $signed(gtdc_pkg::MUL_W'(still_limit_ff));
         end
         ST_ISS_EST: begin
            op_a = gtdc_pkg::MUL_W'(cur_slope);
            op_b = gtdc_pkg::MUL_W'(d_ff);
         end
         ST_ISS_SQ: begin
            op_a = gtdc_pkg::MUL_W'($signed(cur_res[35:8]));
            op_b = gtdc_pkg::MUL_W'($signed(cur_res[35:8]));
         end
         ST_ISS_BH: begin
            op_a = $signed(gtdc_pkg::MUL_W'(bias_rate_ff));
            op_b = gtdc_pkg::MUL_W'($signed(cur_res[35:18]));
         end
         ST_ISS_BL: begin
            op_a = $signed(gtdc_pkg::MUL_W'(bias_rate_ff));
            op_b = $signed(gtdc_pkg::MUL_W'(cur_res[17:0]));
         end
         ST_ISS_NH: begin
            op_a = gtdc_pkg::MUL_W'(d_ff);
            op_b = gtdc_pkg::MUL_W'($signed(cur_res[35:18]));
         end
         ST_ISS_NL: begin
            op_a = gtdc_pkg::MUL_W'(d_ff);
            op_b = $signed(gtdc_pkg::MUL_W'(cur_res[17:0]));
         end
         ST_ISS_QH: begin
            op_a = $signed(gtdc_pkg::MUL_W'(slope_rate_ff));
            op_b = gtdc_pkg::MUL_W'($signed(div_rsp.quo[35:18]));
         end
         ST_ISS_QL: begin
            op_a = $signed(gtdc_pkg::MUL_W'(slope_rate_ff));
            op_b = $signed(gtdc_pkg::MUL_W'(div_rsp.quo[17:0]));
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         primed_ff      <= 1'b0;
         ref_ff         <= '0;
         still_limit_ff <= gtdc_pkg::RST_STILL_LIMIT;
         accel_low_ff   <= gtdc_pkg::RST_ACCEL_LOW;
         accel_high_ff  <= gtdc_pkg::RST_ACCEL_HIGH;
         bias_rate_ff   <= gtdc_pkg::RST_BIAS_RATE;
         slope_rate_ff  <= gtdc_pkg::RST_SLOPE_RATE;
         slope_limit_ff <= gtdc_pkg::RST_SLOPE_LIMIT;
         for (int i = 0; i < gtdc_pkg::AXES; i++) begin
            bias_ff[i]  <= '0;
            slope_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            case (csr_index)
               gtdc_pkg::CSR_STILL_LIMIT: still_limit_ff <= csr_wdata[15:0];
               gtdc_pkg::CSR_ACCEL_LOW:   accel_low_ff   <= csr_wdata[15:0];
               gtdc_pkg::CSR_ACCEL_HIGH:  accel_high_ff  <= csr_wdata[15:0];
               gtdc_pkg::CSR_BIAS_RATE:   bias_rate_ff   <= csr_wdata;
               gtdc_pkg::CSR_SLOPE_RATE:  slope_rate_ff  <= csr_wdata;
               gtdc_pkg::CSR_SLOPE_LIMIT: slope_limit_ff <= csr_wdata[14:0];
               default: ;
            endcase
         end

         // Raise valid when a result is loaded, drop it once the beat is taken.
         if (state_ff == ST_OUTPUT && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  rate_ff[0] <= req_if.rate_x;
                  rate_ff[1] <= req_if.rate_y;
                  rate_ff[2] <= req_if.rate_z;
                  temp_ff    <= req_if.temperature;
                  accel_ff   <= req_if.accel_magnitude;
                  // First beat after reset primes the reference and biases and clears the slopes.
                  if (!primed_ff) begin
                     primed_ff  <= 1'b1;
                     ref_ff     <= req_if.temperature;
                     bias_ff[0] <= {req_if.rate_x, 16'h0000};
                     bias_ff[1] <= {req_if.rate_y, 16'h0000};
                     bias_ff[2] <= {req_if.rate_z, 16'h0000};
                     for (int i = 0; i < gtdc_pkg::AXES; i++) begin
                        slope_ff[i] <= '0;
                     end
                  end
                  state_ff <= ST_LOAD_D;
               end
            end
            ST_LOAD_D: begin
               d_ff     <= gtdc_pkg::DELTA_W'(temp_ff) - gtdc_pkg::DELTA_W'(ref_ff);
               state_ff <= ST_ISS_DSQ;
            end
            ST_ISS_DSQ: begin
               state_ff <= ST_ISS_LSQ;
            end
            ST_ISS_LSQ: begin
               denom_ff <= gtdc_pkg::DEN_W'(prod[32:0]) + 34'd65536;
               state_ff <= ST_GET_LSQ;
            end
            ST_GET_LSQ: begin
               lim2_ff  <= prod[31:0];
               sum_ff   <= '0;
               axis_ff  <= '0;
               pass_ff  <= 1'b0;
               state_ff <= ST_ISS_EST;
            end
            ST_ISS_EST: begin
               state_ff <= ST_GET_EST;
            end
            ST_GET_EST: begin
               res_ff[axis_ff] <= res_new;
               if (!pass_ff) begin
                  state_ff <= ST_ISS_SQ;
               end else if (axis_last) begin
                  state_ff <= ST_OUTPUT;
               end else begin
                  axis_ff  <= axis_ff + 1'b1;
                  state_ff <= ST_ISS_BH;
               end
            end
            ST_ISS_SQ: begin
               state_ff <= ST_GET_SQ;
            end
            ST_GET_SQ: begin
               sum_ff <= sum_ff + gtdc_pkg::SUM_W'($unsigned(prod));
               if (axis_last) begin
                  state_ff <= ST_DECIDE;
               end else begin
                  axis_ff  <= axis_ff + 1'b1;
                  state_ff <= ST_ISS_EST;
               end
            end
            ST_DECIDE: begin
               still_ff <= still_now;
               axis_ff  <= '0;
               pass_ff  <= 1'b1;
               state_ff <= still_now ? ST_ISS_BH : ST_OUTPUT;
            end
            ST_ISS_BH: begin
               state_ff <= ST_ISS_BL;
            end
            ST_ISS_BL: begin
               acc_ff   <= prod_hi;
               state_ff <= ST_ISS_NH;
            end
            ST_ISS_NH: begin
               bias_ff[axis_ff] <= bias_new;
               state_ff         <= ST_ISS_NL;
            end
            ST_ISS_NL: begin
               acc_ff   <= prod_hi;
               state_ff <= ST_GET_NUM;
            end
            ST_GET_NUM: begin
               state_ff <= ST_WAIT_DIV;
            end
            ST_WAIT_DIV: begin
               if (div_rsp.done) begin
                  state_ff <= ST_ISS_QH;
               end
            end
            ST_ISS_QH: begin
               state_ff <= ST_ISS_QL;
            end
            ST_ISS_QL: begin
               acc_ff   <= prod_hi;
               state_ff <= ST_GET_Q;
            end
            ST_GET_Q: begin
               slope_ff[axis_ff] <= slope_new;
               state_ff          <= ST_ISS_EST;
            end
            ST_OUTPUT: begin
               // Hold until the result register drains.
               if (rsp_free) begin
                  fixed_x_ff   <= sat16(res_ff[0]);
                  fixed_y_ff   <= sat16(res_ff[1]);
                  fixed_z_ff   <= sat16(res_ff[2]);
                  was_still_ff <= still_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_div_done_waiting: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_WAIT_DIV)
      else $error("divider finished outside the wait state");

   a_primed_sticks: assert property (@(posedge clock) disable iff (reset)
      primed_ff |=> primed_ff)
      else $error("primed flag dropped without reset");

   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !$rose(rsp_valid_ff))
      else $error("result appeared one cycle after a sample beat");

   a_div_start_primed: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> primed_ff && still_ff)
      else $error("division started without adaptation");
`endif

endmodule
`default_nettype wire
